### rtl/core/mds_pkg.sv
package mds_pkg;

    localparam int SLOTS_PER_QUEUE = 8;
    localparam int QUEUE_COUNT     = 4;

    localparam int REQ_W    = 2;
    localparam int QID_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam int SLOT_W  = $clog2(SLOTS_PER_QUEUE);
    localparam int QIDX_W  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int DEPTH   = QUEUE_COUNT * SLOTS_PER_QUEUE;
    localparam int ADDR_W  = $clog2(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/core/mds_ctrl.sv
module mds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  mds_pkg::t_dp_stat i_stat,
    output mds_pkg::t_dp_cmd  o_cmd
);
    import mds_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/mds_dpath.sv
module mds_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mds_pkg::t_dp_cmd            i_cmd,
    output mds_pkg::t_dp_stat           o_stat,
    input  logic [mds_pkg::REQ_W-1:0]   i_req_type,
    input  logic [mds_pkg::QID_W-1:0]   i_queue_id,
    input  logic signed [mds_pkg::DATA_W-1:0] i_push_value,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic [mds_pkg::STATUS_W-1:0] o_status,
    output logic signed [mds_pkg::DATA_W-1:0] o_pop_value
);
    import mds_pkg::*;

    // latched request
    t_req                r_op;
    logic [QID_W-1:0]    r_qid;
    logic [DATA_W-1:0]   r_val;

    // per-queue pointers
    logic [SLOT_W-1:0]      r_head [QUEUE_COUNT];
    logic [SLOT_W-1:0]      r_tail [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] r_empty;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    t_status             r_status;
    logic                r_pop_ok;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [DATA_W-1:0]   r_out_pop;

    logic [QIDX_W-1:0]   w_qi;
    logic                w_q_ok;
    logic [SLOT_W-1:0]   w_head;
    logic [SLOT_W-1:0]   w_tail;
    logic                w_is_push;
    logic [SLOT_W-1:0]   n_head;
    logic [SLOT_W-1:0]   n_tail;
    logic                n_empty;
    t_status             n_status;
    logic                n_pop_ok;
    logic                w_we;
    logic                w_re;
    logic [SLOT_W-1:0]   w_slot;
    logic [ADDR_W-1:0]   w_addr;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        slot_next = (s == SLOT_W'(SLOTS_PER_QUEUE - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
        slot_prev = (s == '0) ? SLOT_W'(SLOTS_PER_QUEUE - 1) : s - SLOT_W'(1);
    endfunction

    assign w_qi      = QIDX_W'(r_qid);
    assign w_q_ok    = int'(r_qid) < QUEUE_COUNT;
    assign w_head    = r_head[w_qi];
    assign w_tail    = r_tail[w_qi];
    assign w_is_push = (r_op == REQ_PUSH_FRONT) || (r_op == REQ_PUSH_REAR);
    assign w_addr    = ADDR_W'(w_qi) * ADDR_W'(SLOTS_PER_QUEUE) + ADDR_W'(w_slot);

    always_comb begin
        n_head   = w_head;
        n_tail   = w_tail;
        n_empty  = r_empty[w_qi];
        n_status = STATUS_DONE;
        n_pop_ok = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_slot   = '0;
        if (!w_q_ok) begin
            n_status = w_is_push ? STATUS_FULL : STATUS_EMPTY;
        end else if (w_is_push) begin
            if (r_empty[w_qi]) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b0;
                w_we    = 1'b1;
                w_slot  = '0;
            end else if (slot_next(w_tail) == w_head) begin
                n_status = STATUS_FULL;
            end else if (r_op == REQ_PUSH_FRONT) begin
                n_head = slot_prev(w_head);
                w_we   = 1'b1;
                w_slot = slot_prev(w_head);
            end else begin
                n_tail = slot_next(w_tail);
                w_we   = 1'b1;
                w_slot = slot_next(w_tail);
            end
        end else begin
            if (r_empty[w_qi]) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_pop_ok = 1'b1;
                w_re     = 1'b1;
                w_slot   = (r_op == REQ_POP_FRONT) ? w_head : w_tail;
                if (w_head == w_tail) begin
                    n_empty = 1'b1;
                end else if (r_op == REQ_POP_FRONT) begin
                    n_head = slot_next(w_head);
                end else begin
                    n_tail = slot_prev(w_tail);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_req'(i_req_type);
            r_qid <= i_queue_id;
            r_val <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
            end
            r_empty <= '1;
        end else if (i_cmd.exec && w_q_ok) begin
            r_head[w_qi]  <= n_head;
            r_tail[w_qi]  <= n_tail;
            r_empty[w_qi] <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_addr] <= r_val;
        end
        if (i_cmd.exec && w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_pop    <= r_pop_ok ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_pop_value     = r_out_pop;

endmodule

### rtl/core/multi_deque_shared_store.sv
// flow: the controller's idle step latches a request, the execute step applies it to the
// single-port slot store, and the emit step registers the result once the previous result
// has been taken; no new request is accepted until the emit step completes
// reset: synchronous active-low; every queue empty, pointers at slot zero,
// slot store contents undefined until written
module multi_deque_shared_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  logic [mds_pkg::REQ_W-1:0]          i_req_type,
    input  logic [mds_pkg::QID_W-1:0]          i_queue_id,
    input  logic signed [mds_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_ready,
    output logic [mds_pkg::STATUS_W-1:0]       o_status,
    output logic signed [mds_pkg::DATA_W-1:0]  o_pop_value
);
    import mds_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mds_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (i_req_type),
        .i_queue_id   (i_queue_id),
        .i_push_value (i_push_value),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value)
    );

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status != STATUS_DONE) |-> o_pop_value == '0)
        else $error("refused request carries a nonzero pop value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while another is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_rsp_valid || i_rsp_ready))
        else $error("result register overwritten before it was taken");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import mds_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 66;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  value;
    } t_deque_outcome;

    typedef struct packed {
        t_req                      req;
        logic [QID_W-1:0]          qid;
        logic signed [DATA_W-1:0]  value;
        logic                      typed;
        t_status                   status;
        logic signed [DATA_W-1:0]  popped;
    } t_request_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_req_valid;
    logic                       o_req_ready;
    t_req                       i_req_type;
    logic [QID_W-1:0]           i_queue_id;
    logic signed [DATA_W-1:0]   i_push_value;
    logic                       o_rsp_valid;
    logic                       i_rsp_ready;
    logic [STATUS_W-1:0]        o_status;
    logic signed [DATA_W-1:0]   o_pop_value;

    multi_deque_shared_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_queue_id   (i_queue_id),
        .i_push_value (i_push_value),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value)
    );

    // mirror of the queue state
    logic [SLOT_W-1:0]          mirror_head [QUEUE_COUNT];
    logic [SLOT_W-1:0]          mirror_tail [QUEUE_COUNT];
    logic                       mirror_empty [QUEUE_COUNT];
    logic signed [DATA_W-1:0]   mirror_slots [DEPTH];

    t_deque_outcome             pending_outcomes [$];

    int  cycle_count = 0;
    int  error_count;
    int  requests_sent;
    int  results_seen;
    int  pops_done;
    int  full_refusals;
    int  empty_refusals;
    int  burst_left;
    bit  steady_sender;
    bit  rsp_hold_req;

    t_request_row directed_rows [25] = '{
        '{REQ_POP_FRONT,  2'd0, 32'sh0000_0000, 1'b1, STATUS_EMPTY, 32'sh0000_0000},
        '{REQ_POP_REAR,   2'd1, 32'sh5a5a_5a5a, 1'b1, STATUS_EMPTY, 32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd0, 32'sh7fff_ffff, 1'b1, STATUS_DONE,  32'sh0000_0000},
        '{REQ_POP_REAR,   2'd0, 32'sh0000_0000, 1'b1, STATUS_DONE,  32'sh7fff_ffff},
        '{REQ_PUSH_REAR,  2'd1, 32'sh8000_0000, 1'b1, STATUS_DONE,  32'sh0000_0000},
        '{REQ_POP_FRONT,  2'd1, 32'sh0000_0000, 1'b1, STATUS_DONE,  32'sh8000_0000},
        '{REQ_POP_FRONT,  2'd1, 32'sh0000_0000, 1'b1, STATUS_EMPTY, 32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd2, 32'sh0000_0001, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd2, 32'sh0000_0002, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd2, 32'sh0000_0003, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd2, 32'sh0000_0004, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd2, 32'sh0000_0005, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd2, 32'sh0000_0006, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd2, 32'sh0000_0007, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd2, 32'sh0000_0008, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd2, 32'sh1234_5678, 1'b1, STATUS_FULL,  32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd2, 32'shedcb_a987, 1'b1, STATUS_FULL,  32'sh0000_0000},
        '{REQ_POP_FRONT,  2'd2, 32'sh0000_0000, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_POP_REAR,   2'd2, 32'sh0000_0000, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd2, 32'sh0000_0009, 1'b0, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_FRONT, 2'd3, 32'shffff_ffff, 1'b1, STATUS_DONE,  32'sh0000_0000},
        '{REQ_PUSH_REAR,  2'd3, 32'sh0000_0000, 1'b1, STATUS_DONE,  32'sh0000_0000},
        '{REQ_POP_REAR,   2'd3, 32'sh0000_0000, 1'b1, STATUS_DONE,  32'sh0000_0000},
        '{REQ_POP_REAR,   2'd3, 32'sh0000_0000, 1'b1, STATUS_DONE,  32'shffff_ffff},
        '{REQ_POP_FRONT,  2'd3, 32'sh0000_0000, 1'b1, STATUS_EMPTY, 32'sh0000_0000}
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] s);
        return (int'(s) == SLOTS_PER_QUEUE - 1) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_before(logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(SLOTS_PER_QUEUE - 1) : s - SLOT_W'(1);
    endfunction

    function automatic t_deque_outcome apply_deque_request(t_req req, logic [QID_W-1:0] qid,
                                                           logic signed [DATA_W-1:0] value);
        t_deque_outcome res;
        bit             is_push;
        int             base;
        res.status = STATUS_DONE;
        res.value  = '0;
        is_push    = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_REAR);
        base       = int'(qid) * SLOTS_PER_QUEUE;
        if (int'(qid) >= QUEUE_COUNT) begin
            res.status = is_push ? STATUS_FULL : STATUS_EMPTY;
        end else if (is_push) begin
            if (mirror_empty[qid]) begin
                mirror_head[qid]  = '0;
                mirror_tail[qid]  = '0;
                mirror_empty[qid] = 1'b0;
                mirror_slots[base] = value;
            end else if (slot_after(mirror_tail[qid]) == mirror_head[qid]) begin
                res.status = STATUS_FULL;
            end else if (req == REQ_PUSH_FRONT) begin
                mirror_head[qid] = slot_before(mirror_head[qid]);
                mirror_slots[base + int'(mirror_head[qid])] = value;
            end else begin
                mirror_tail[qid] = slot_after(mirror_tail[qid]);
                mirror_slots[base + int'(mirror_tail[qid])] = value;
            end
        end else if (mirror_empty[qid]) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.value = mirror_slots[base + int'((req == REQ_POP_FRONT) ? mirror_head[qid]
                                                                         : mirror_tail[qid])];
            if (mirror_head[qid] == mirror_tail[qid]) begin
                mirror_empty[qid] = 1'b1;
            end else if (req == REQ_POP_FRONT) begin
                mirror_head[qid] = slot_after(mirror_head[qid]);
            end else begin
                mirror_tail[qid] = slot_before(mirror_tail[qid]);
            end
        end
        return res;
    endfunction

    task automatic offer_request(t_req req, logic [QID_W-1:0] qid,
                                 logic signed [DATA_W-1:0] value,
                                 logic typed, t_deque_outcome typed_outcome);
        t_deque_outcome predicted;
        @(negedge i_clk);
        i_req_valid  = 1'b1;
        i_req_type   = req;
        i_queue_id   = qid;
        i_push_value = value;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        predicted = apply_deque_request(req, qid, value);
        pending_outcomes.push_back(typed ? typed_outcome : predicted);
        requests_sent++;
    endtask

    // bursts of requests, separated by idle gaps unless the sender is set steady
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if (!steady_sender) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                i_req_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // receiver ready pattern, with a long hold-off on request
    initial begin : receiver
        int mode;
        int mode_left;
        int held;
        i_rsp_ready = 1'b0;
        mode        = 0;
        mode_left   = 0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_req) begin
                i_rsp_ready = 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge i_clk);
                rsp_hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 60);
                end
                mode_left--;
                case (mode)
                    0:       i_rsp_ready = 1'b1;
                    1:       i_rsp_ready = 1'($urandom_range(0, 1));
                    default: i_rsp_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_deque_outcome want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d value %h", o_status, o_pop_value);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status || o_pop_value !== want.value) begin
                    error_count++;
                    if (error_count <= 10) begin
                        if (o_status !== want.status)
                            $display("result %0d status: expected %0d got %0d",
                                     results_seen, want.status, o_status);
                        if (o_pop_value !== want.value)
                            $display("result %0d pop value: expected %h got %h",
                                     results_seen, want.value, o_pop_value);
                    end
                end
                if (o_status === STATUS_FULL) full_refusals++;
                if (o_status === STATUS_EMPTY) empty_refusals++;
                if (o_status === STATUS_DONE && want.status == STATUS_DONE
                    && o_pop_value !== '0) pops_done++;
            end
        end
    end

    initial begin : stimulus
        t_deque_outcome typed_outcome;
        t_deque_outcome unused_outcome;
        t_req           req;
        logic [QID_W-1:0] qid;
        int             phase;
        int             item;
        int             focus;
        int             push_pct;
        error_count    = 0;
        requests_sent  = 0;
        results_seen   = 0;
        pops_done      = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        burst_left     = 0;
        steady_sender  = 1'b0;
        rsp_hold_req   = 1'b0;
        unused_outcome = '0;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_req_valid    = 1'b0;
        i_req_type     = REQ_PUSH_FRONT;
        i_queue_id     = '0;
        i_push_value   = '0;
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            mirror_head[q]  = '0;
            mirror_tail[q]  = '0;
            mirror_empty[q] = 1'b1;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            pace_sender();
            typed_outcome.status = directed_rows[i].status;
            typed_outcome.value  = directed_rows[i].popped;
            offer_request(directed_rows[i].req, directed_rows[i].qid, directed_rows[i].value,
                          directed_rows[i].typed, typed_outcome);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 3)
                rsp_hold_req = 1'b1;
            if (phase == 5) begin
                @(negedge i_clk);
                i_req_valid = 1'b0;
                wait_drained();
            end
            steady_sender = (phase == 2) || (phase == 6);
            focus         = $urandom_range(0, QUEUE_COUNT - 1);
            case (phase % 3)
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            for (item = 0; item < PHASE_ITEMS; item++) begin
                pace_sender();
                if ($urandom_range(1, 100) <= push_pct)
                    req = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
                else
                    req = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
                qid = ($urandom_range(0, 9) < 7) ? QID_W'(focus) : QID_W'($urandom);
                offer_request(req, qid, pick_value(), 1'b0, unused_outcome);
            end
        end

        @(negedge i_clk);
        i_req_valid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d requests over all four queues, %0d results checked", requests_sent,
                 results_seen);
        $display("refused full %0d, refused empty %0d, nonzero pops %0d, mismatches %0d",
                 full_refusals, empty_refusals, pops_done, error_count);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
